// ===== src/sha_pkg.sv =====
// Package for the streaming SHA-256 hash: round constants, initial hash
// values, sequencer state type and a rotate-right helper function. No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS     = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/sha256_stream_hash.sv =====
// Streaming SHA-256 hash top level: byte collection, padding, one shared
// round unit with a rolling 16-word schedule, digest output register.
// Depends on sha_pkg.
`timescale 1ns / 1ps

// One input beat carries at most one message byte and may end the message.
// A beat that neither completes a 64-byte block nor ends the message
// leaves s_tready high for the next beat. A beat that completes a block
// keeps s_tready low while the single round unit runs 64 rounds and an
// add step. The first round also loads word 0 of the block. The schedule
// words live in a 16-entry shift line. An end-of-message beat first waits
// for any block that its own byte completed. It then runs a padding step
// and a compression on each of one or two padded blocks. Two blocks are
// needed when fewer than nine bytes of room remain. The block then
// presents the eight digest words on the master side, H0 first, and
// accepts nothing until the last word beat has been taken. The hash then
// restarts for the next message.
module sha256_stream_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    import sha_pkg::*;

    state_t state_reg, state_next;

    logic [31:0] blk_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] count_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [6:0]  step_reg;
    logic        final_reg;   // the block in flight is the last padded one
    logic        padding_reg; // the message is being finished
    logic        second_reg;  // a second padded block is still needed
    logic [2:0]  out_idx_reg;

    logic        in_fire, out_fire;
    logic        take_byte, block_full;
    logic        pad_len;
    logic [31:0] w_new, w_cur;
    logic [31:0] t1, t2;
    logic [63:0] bit_len;

    assign in_fire    = s_tvalid && s_tready;
    assign out_fire   = m_tvalid && m_tready;
    assign take_byte  = in_fire && s_tuser;
    assign block_full = take_byte && (fill_reg == 6'd63);
    assign bit_len    = {count_reg, 3'b000};
    assign pad_len    = second_reg || (fill_reg < 6'(LEN_POS));

    // Schedule: for the first 16 rounds the word comes from the buffer, else expanded.
    always_comb
    begin
        logic [31:0] lo, hi;
        lo    = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        hi    = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + lo + w_reg[9] + hi;
    end

    always_comb
    begin
        logic [31:0] big_e, choose, big_a, major;
        w_cur  = (step_reg < 7'd16) ? blk_reg[step_reg[3:0]] : w_new;
        big_e  = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1     = v_reg[7] + big_e + choose + ROUND_K[step_reg[5:0]] + w_cur;
        big_a  = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2     = big_a + major;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (block_full)
                    state_next = ST_LOAD;
                else if (in_fire && s_tlast)
                    state_next = ST_PAD;
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (step_reg == 7'd63) state_next = ST_ADD;
            ST_ADD:
            begin
                if (final_reg)
                    state_next = ST_EMIT;
                else if (padding_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:   state_next = ST_LOAD;
            ST_EMIT:  if (out_fire && out_idx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_EMIT);
        m_tdata  = {5'd0, out_idx_reg, h_reg[out_idx_reg]};
        m_tlast  = (out_idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            final_reg   <= 1'b0;
            padding_reg <= 1'b0;
            second_reg  <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_HASH[i];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
                w_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take_byte)
                    begin
                        fill_reg  <= fill_reg + 6'd1;
                        count_reg <= count_reg + 61'd1;
                    end
                    if (in_fire && s_tlast)
                        padding_reg <= 1'b1;
                    step_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                end
                ST_PAD:
                begin
                    if (!second_reg)
                    begin
                        if (fill_reg >= 6'(LEN_POS))
                        begin
                            second_reg <= 1'b1;
                            final_reg  <= 1'b0;
                        end
                        else
                        begin
                            final_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        second_reg <= 1'b0;
                        final_reg  <= 1'b1;
                    end
                    step_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                end
                ST_LOAD, ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++)
                        w_reg[i] <= w_reg[i + 1];
                    w_reg[15] <= w_cur;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    step_reg <= step_reg + 7'd1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    out_idx_reg <= '0;
                end
                ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= INIT_HASH[i];
                            fill_reg    <= '0;
                            count_reg   <= '0;
                            padding_reg <= 1'b0;
                            final_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // The block is kept as 16 big-endian words and has no reset. In the
    // padding cycle fill_reg points just past the data bytes.
    always_ff @(posedge clk)
    begin
        if (take_byte)
            blk_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= s_tdata;
        else if (state_reg == ST_PAD)
        begin
            for (int j = 0; j < 16; j++)
            begin
                if (pad_len && j >= LEN_POS / 4)
                    blk_reg[4'(j)] <= (j == 14) ? bit_len[63:32] : bit_len[31:0];
                else
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (second_reg || 6'(4 * j + k) > fill_reg)
                            blk_reg[4'(j)][8 * (3 - k) +: 8] <= 8'h00;
                        else if (6'(4 * j + k) == fill_reg)
                            blk_reg[4'(j)][8 * (3 - k) +: 8] <= PAD_BYTE;
                    end
                end
            end
        end
    end

    // ST_LOAD covers round 0; ST_ROUND runs rounds 1..63.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input ready while digest is being presented");
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        block_full |=> (state_reg == ST_LOAD && fill_reg == 6'd0))
        else $error("full block did not start compression");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_idx_reg)))
        else $error("digest word index moved while stalled");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> (s_tready && count_reg == 61'd0))
        else $error("hash did not restart after last digest word");

endmodule

// ===== sim/sha256_stream_hash_tb.sv =====
// Testbench for the streaming SHA-256 hash: drives byte beats with random gaps,
// predicts every digest word with its own SHA-256 model and checks the output beats.
// Depends on sha_pkg (round constants, initial hash values) and sha256_stream_hash.
`timescale 1ns / 1ps

class digest_scoreboard;
    logic [31:0] state_h [8];
    logic [7:0]  blk [64];
    int unsigned fill;
    logic [60:0] nbytes;
    logic [31:0] want_word [$];
    logic [2:0]  want_index [$];
    logic        want_last [$];
    int unsigned errors;
    int unsigned words_seen;
    int unsigned messages;

    function new();
        errors = 0;
        words_seen = 0;
        messages = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) state_h[i] = sha_pkg::INIT_HASH[i];
        fill = 0;
        nbytes = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        a = state_h[0]; b = state_h[1]; c = state_h[2]; d = state_h[3];
        e = state_h[4]; f = state_h[5]; g = state_h[6]; h = state_h[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + sha_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        state_h[0] += a; state_h[1] += b; state_h[2] += c; state_h[3] += d;
        state_h[4] += e; state_h[5] += f; state_h[6] += g; state_h[7] += h;
    endfunction

    // Notes one accepted input beat and queues a digest when it ends a message.
    function void note_input(logic [7:0] data, logic byte_ok, logic eom);
        logic [63:0] bits;
        if (byte_ok)
        begin
            blk[fill] = data;
            fill++;
            nbytes++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        end
        if (!eom) return;
        blk[fill] = sha_pkg::PAD_BYTE;
        fill++;
        if (fill > sha_pkg::LEN_POS)
        begin
            while (fill < 64) blk[fill++] = 8'h00;
            compress();
            fill = 0;
        end
        while (fill < sha_pkg::LEN_POS) blk[fill++] = 8'h00;
        bits = {nbytes, 3'b000};
        for (int i = 0; i < 8; i++) blk[sha_pkg::LEN_POS + i] = bits[63 - 8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            want_word.push_back(state_h[i]);
            want_index.push_back(i[2:0]);
            want_last.push_back(i == 7);
        end
        messages++;
        restart();
    endfunction

    function void check_word(logic [39:0] tdata, logic tlast);
        logic [31:0] ew;
        logic [2:0]  ei;
        logic        el;
        words_seen++;
        if (want_word.size() == 0)
        begin
            $error("digest word %h arrived with nothing expected", tdata[31:0]);
            errors++;
            return;
        end
        ew = want_word.pop_front();
        ei = want_index.pop_front();
        el = want_last.pop_front();
        if (tdata[31:0] !== ew)
        begin
            $error("digest_word: expected %h, got %h", ew, tdata[31:0]);
            errors++;
        end
        if (tdata[34:32] !== ei)
        begin
            $error("word_index: expected %0d, got %0d", ei, tdata[34:32]);
            errors++;
        end
        if (tdata[39:35] !== 5'd0)
        begin
            $error("tdata padding: expected 0, got %h", tdata[39:35]);
            errors++;
        end
        if (tlast !== el)
        begin
            $error("last_word: expected %b, got %b", el, tlast);
            errors++;
        end
    endfunction

    function int pending();
        return want_word.size();
    endfunction
endclass

module sha256_stream_hash_tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_scoreboard digests;
    int unsigned idle_cycles;
    int unsigned beats_in;
    bit          hold_output;
    bit          stim_done;

    localparam int unsigned STALL_LIMIT = 5000;

    sha256_stream_hash dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Sends one beat after a random gap; returns at the falling edge after
    // the beat is taken, leaving the next beat or the caller to drop valid.
    task automatic send_beat(input logic [7:0] data, input logic byte_ok, input logic eom);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= byte_ok;
        s_tlast  <= eom;
        do @(posedge clk); while (!s_tready);
        digests.note_input(data, byte_ok, eom);
        beats_in++;
        @(negedge clk);
    endtask

    // One message of random bytes; a few beats carry no byte, and the
    // end beat may or may not carry the final byte.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1))
            begin
                send_beat(8'($urandom), 1'b1, 1'b1);
                return;
            end
            send_beat(8'($urandom), 1'b1, 1'b0);
        end
        send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready) digests.check_word(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (rst_n) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls per beat, with a long hold-off when the stimulus asks for one.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_output = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stim_done && digests.pending() == 0) gap = 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        digests = new();
        idle_cycles = 0;
        beats_in = 0;
        hold_output = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty message, then an empty end right after a digest.
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        // "abc" with the last byte on the end beat, extreme byte values.
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        // A full block, then a length that needs a second padding block.
        send_message(64);

        // The receiver holds off while a digest waits, so the block stalls its input.
        hold_output = 1'b1;
        send_message(56);

        while (beats_in < 130) send_message($urandom_range(0, 6));
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (digests.pending() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Covered %0d input beats, %0d messages, %0d digest words.",
                 beats_in, digests.messages, digests.words_seen);
        $display("Messages ranged from empty to one full block, with padding spills.");
        if (digests.errors == 0 && digests.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
